[src/oal_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered array list package
// Shared widths, request and status codes, and the cell control word.
// ----------------------------------------------------------------------------
package oal_pkg;

  localparam int unsigned DepthDef      = 64;
  localparam int unsigned ValueWidthDef = 32;

  localparam int unsigned PosW    = 6;
  localparam int unsigned StatusW = 3;
  localparam int unsigned FoundW  = 6;
  localparam int unsigned CountW  = 7;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_CLEAR  = 2'd3
  } oal_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } oal_status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_FIND   = 2'd3
  } oal_op_e;

  // Broadcast to every cell in the row.
  typedef struct packed {
    oal_op_e         op;
    logic [PosW-1:0] pos;
  } oal_ctrl_t;

endpackage

[src/oal_if.sv]
// ----------------------------------------------------------------------------
// Ordered array list channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface oal_req_if import oal_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [PosW-1:0]               position;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface oal_rsp_if import oal_pkg::*;;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [FoundW-1:0]  found_index;
  logic [CountW-1:0]  count;

  modport source (output valid, status, found_index, count, input ready);
  modport sink   (input valid, status, found_index, count, output ready);
endinterface

[src/oal_cell.sv]
// ----------------------------------------------------------------------------
// Ordered array list cell
// Holds one list entry; shifts to or from its neighbors and compares.
// ----------------------------------------------------------------------------
module oal_cell import oal_pkg::*; #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic                   clk_i,
  input  oal_ctrl_t              ctrl_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [VALUE_WIDTH-1:0] left_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  input  logic                   valid_i,
  output logic [VALUE_WIDTH-1:0] data_o,
  output logic                   match_o
);

  logic [VALUE_WIDTH-1:0] data_q, data_d;
  logic                   match_q, match_d;
  logic                   at_pos, above_pos;

  assign at_pos    = (32'(ctrl_i.pos) == IDX);
  assign above_pos = (IDX > 32'(ctrl_i.pos));

  always_comb begin
    data_d  = data_q;
    match_d = match_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (above_pos) begin
          data_d = left_i;
        end else if (at_pos) begin
          data_d = value_i;
        end
      end
      OP_DELETE: begin
        if (above_pos || at_pos) begin
          data_d = right_i;
        end
      end
      OP_FIND: begin
        match_d = valid_i && (data_q == value_i);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

[src/ordered_array_list_engine.sv]
// ----------------------------------------------------------------------------
// Ordered array list engine
// Bounded ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request item: kind (insert, delete, find, clear),
//   position and value. rsp_o returns exactly one result item per request
//   with status, found_index and the entry count after the request.
//   Insert, delete and clear: every cell shifts or holds in the accept
//   cycle, and the result is in the output register in the cycle after.
//   Find: the cells compare in parallel and register a match bit, then a
//   priority encoder over the match bits picks the lowest position. One
//   request is in flight at a time, so a new item is taken once the
//   previous one has reached the output register and that register is
//   empty or being drained; while it is, insert, delete and clear take one
//   item per cycle; a find holds off the next item until its result loads.
//   Reset empties the list and the output register; entries keep stale
//   data and are never read beyond the count. While the receiver stalls,
//   the result holds and req_i.ready stays low.
// ----------------------------------------------------------------------------
module ordered_array_list_engine import oal_pkg::*; #(
  parameter int unsigned DEPTH       = DepthDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  oal_req_if.sink   req_i,
  oal_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FIND = 2'b10
  } oal_state_e;

  oal_state_e             state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   rsp_valid_q;
  oal_status_e            rsp_status_q, status_d;
  logic [FoundW-1:0]      rsp_found_q;
  logic [CntW-1:0]        rsp_count_q;
  logic                   accept;
  oal_kind_e              kind;
  oal_ctrl_t              ctrl;
  logic [VALUE_WIDTH-1:0] req_value;
  logic [DEPTH-1:0]       match;
  logic [VALUE_WIDTH-1:0] data [DEPTH];
  oal_status_e            find_status;
  logic [FoundW-1:0]      find_idx;
  logic                   load_now;

  assign req_i.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign kind        = oal_kind_e'(req_i.kind);

  // Request decode: checks and cell command for the accept cycle.
  always_comb begin
    status_d = ST_OK;
    count_d  = count_q;
    state_d  = state_q;
    ctrl.op  = OP_HOLD;
    ctrl.pos = req_i.position;
    if (accept) begin
      unique case (kind)
        KIND_INSERT: begin
          if (count_q == CntW'(DEPTH)) begin
            status_d = ST_FULL;
          end else if (32'(req_i.position) > 32'(count_q)) begin
            status_d = ST_BADPOS;
          end else begin
            ctrl.op = OP_INSERT;
            count_d = count_q + 1'b1;
          end
        end
        KIND_DELETE: begin
          if (32'(req_i.position) >= 32'(count_q)) begin
            status_d = ST_BADPOS;
          end else begin
            ctrl.op = OP_DELETE;
            count_d = count_q - 1'b1;
          end
        end
        KIND_FIND: begin
          ctrl.op = OP_FIND;
          state_d = S_FIND;
        end
        KIND_CLEAR: begin
          count_d = '0;
        end
        default: ;
      endcase
    end else if (state_q == S_FIND) begin
      state_d = S_IDLE;
    end
  end

  assign req_value = VALUE_WIDTH'(req_i.value);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = data[i+1];
    end
    oal_cell #(
      .IDX         (i),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (req_value),
      .left_i  (left),
      .right_i (right),
      .valid_i (i < int'(count_q)),
      .data_o  (data[i]),
      .match_o (match[i])
    );
  end

  // Lowest matching position wins, so scan from the top down.
  always_comb begin
    find_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        find_idx = FoundW'(i);
      end
    end
    if (count_q == '0) begin
      find_status = ST_EMPTY;
    end else if (match == '0) begin
      find_status = ST_NOTFOUND;
    end else begin
      find_status = ST_OK;
    end
  end

  assign load_now = (accept && (kind != KIND_FIND)) || (state_q == S_FIND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_now) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_now) begin
      rsp_count_q <= count_d;
      if (state_q == S_FIND) begin
        rsp_status_q <= find_status;
        rsp_found_q  <= (find_status == ST_OK) ? find_idx : '0;
      end else begin
        rsp_status_q <= status_d;
        rsp_found_q  <= '0;
      end
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found_index = rsp_found_q;
  assign rsp_o.count       = CountW'(rsp_count_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("entry count exceeds depth");

  a_find_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (kind == KIND_FIND) |=> state_q == S_FIND)
    else $error("find request did not enter the match stage");

  a_find_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIND |-> !req_i.ready && !rsp_valid_q)
    else $error("match stage overlaps another item");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(accept) || $past(state_q == S_FIND))
    else $error("result item without a request");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (kind == KIND_CLEAR) |=> count_q == '0)
    else $error("clear left entries in the list");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list engine testbench
// Drives insert, delete, find and clear requests through the request channel
// and checks every response against a shadow copy of the list. Both channels
// idle at random. One stretch holds the response channel off so that the
// engine stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  import oal_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned VW           = 32;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct {
    oal_kind_e         kind;
    logic [PosW-1:0]   pos;
    logic [VW-1:0]     value;
    oal_status_e       status;
    logic [FoundW-1:0] found;
    logic [CountW-1:0] count;
  } list_result_t;

  logic clk_i;
  logic rst_ni;

  oal_req_if #(.VALUE_WIDTH(VW)) req_if ();
  oal_rsp_if                     rsp_if ();

  ordered_array_list_engine #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VW)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the list contents, position 0 first.
  logic [VW-1:0] shadow_list[$];
  list_result_t  pending_results[$];

  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  bit          sender_idle  = 1'b1;
  bit          receiver_idle = 1'b1;
  int unsigned hold_request = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Applies one request to the shadow list and returns the expected response.
  function automatic list_result_t apply_list_request(input oal_kind_e kind,
                                                      input logic [PosW-1:0] pos,
                                                      input logic [VW-1:0] value);
    list_result_t res;
    res.kind   = kind;
    res.pos    = pos;
    res.value  = value;
    res.status = ST_OK;
    res.found  = '0;
    case (kind)
      KIND_INSERT: begin
        if (shadow_list.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else if (pos > shadow_list.size()) begin
          res.status = ST_BADPOS;
        end else begin
          shadow_list.insert(pos, value);
        end
      end
      KIND_DELETE: begin
        if (pos >= shadow_list.size()) begin
          res.status = ST_BADPOS;
        end else begin
          shadow_list.delete(pos);
        end
      end
      KIND_FIND: begin
        if (shadow_list.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOTFOUND;
          foreach (shadow_list[j]) begin
            if (res.status == ST_NOTFOUND && shadow_list[j] == value) begin
              res.status = ST_OK;
              res.found  = FoundW'(j);
            end
          end
        end
      end
      default: begin
        shadow_list.delete();
      end
    endcase
    res.count = CountW'(shadow_list.size());
    return res;
  endfunction

  task automatic send_req(input oal_kind_e kind, input logic [PosW-1:0] pos,
                          input logic [VW-1:0] value);
    int unsigned gap;
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.kind     <= kind;
    req_if.position <= pos;
    req_if.value    <= value;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(apply_list_request(kind, pos, value));
  endtask

  function automatic logic [VW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(0, 8) - 4;
      7:          return $urandom_range(0, 1) ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
      default: begin
        if (shadow_list.size() != 0) return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        return $urandom;
      end
    endcase
  endfunction

  task automatic note_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at cycle %0d: %s", cycle_count, what);
  endtask

  // Response channel: random short stalls, plus a long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left  = 0;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("response with none pending: status %0d index %0d count %0d",
                                rsp_if.status, rsp_if.found_index, rsp_if.count));
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_if.status !== exp_res.status || rsp_if.found_index !== exp_res.found ||
            rsp_if.count !== exp_res.count) begin
          note_mismatch($sformatf({"%s pos %0d value %0h: expected status %0d index %0d ",
                                   "count %0d, got status %0d index %0d count %0d"},
                                  exp_res.kind.name(), exp_res.pos, exp_res.value,
                                  exp_res.status, exp_res.found, exp_res.count,
                                  rsp_if.status, rsp_if.found_index, rsp_if.count));
        end
      end
    end
  end

  // Every kind of request against an empty list.
  task automatic test_empty_list();
    send_req(KIND_FIND, 6'd0, 32'd0);
    send_req(KIND_DELETE, 6'd0, 32'd0);
    send_req(KIND_DELETE, 6'd63, 32'hFFFF_FFFF);
    send_req(KIND_INSERT, 6'd1, 32'd5);
    send_req(KIND_CLEAR, 6'd63, 32'hFFFF_FFFF);
  endtask

  // Short edits with extreme values, duplicates and shifting.
  task automatic test_edit_and_find();
    send_req(KIND_INSERT, 6'd0, 32'h8000_0000);
    send_req(KIND_INSERT, 6'd1, 32'h7FFF_FFFF);
    send_req(KIND_INSERT, 6'd0, 32'h0000_0000);
    send_req(KIND_INSERT, 6'd4, 32'd9);
    send_req(KIND_INSERT, 6'd63, 32'd9);
    send_req(KIND_FIND, 6'd63, 32'hFFFF_FFFF);
    send_req(KIND_FIND, 6'd0, 32'h8000_0000);
    send_req(KIND_FIND, 6'd0, 32'h7FFF_FFFF);
    send_req(KIND_INSERT, 6'd3, 32'h8000_0000);
    send_req(KIND_FIND, 6'd0, 32'h8000_0000);
    send_req(KIND_DELETE, 6'd1, 32'd0);
    send_req(KIND_FIND, 6'd0, 32'h8000_0000);
    send_req(KIND_DELETE, 6'd3, 32'd0);
    send_req(KIND_DELETE, 6'd2, 32'hFFFF_FFFF);
    send_req(KIND_FIND, 6'd0, 32'h7FFF_FFFF);
    send_req(KIND_CLEAR, 6'd0, 32'd0);
    send_req(KIND_FIND, 6'd0, 32'h0000_0000);
  endtask

  // Fill to capacity, then hit the full list and its last entry.
  task automatic test_full_list();
    int unsigned i;
    for (i = 0; i < DEPTH; i++) begin
      send_req(KIND_INSERT, PosW'($urandom_range(0, shadow_list.size())), 32'd1000 + i);
    end
    send_req(KIND_INSERT, 6'd0, 32'd1);
    send_req(KIND_INSERT, 6'd63, 32'd2);
    send_req(KIND_FIND, 6'd0, shadow_list[DEPTH-1]);
    send_req(KIND_FIND, 6'd0, shadow_list[0]);
    send_req(KIND_DELETE, 6'd63, 32'd0);
    send_req(KIND_INSERT, 6'd63, 32'h8000_0000);
    send_req(KIND_FIND, 6'd0, 32'h8000_0000);
    send_req(KIND_CLEAR, 6'd0, 32'd0);
  endtask

  // Hold the response channel off while requests keep coming.
  task automatic test_backpressure();
    int unsigned i;
    hold_request = 60;
    for (i = 0; i < 20; i++) begin
      if (i % 3 == 2) send_req(KIND_FIND, PosW'($urandom), pick_value());
      else send_req(KIND_INSERT, PosW'($urandom_range(0, shadow_list.size())), pick_value());
    end
  endtask

  task automatic test_random_traffic();
    int unsigned i;
    int unsigned roll;
    int unsigned size;
    bit          growing;
    oal_kind_e   kind;
    logic [PosW-1:0] pos;
    growing = 1'b1;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS * 4 / 5) begin
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
      end
      if (i % 100 == 0) growing = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (growing) begin
        kind = roll < 55 ? KIND_INSERT : roll < 70 ? KIND_DELETE : roll < 98 ? KIND_FIND
                         : KIND_CLEAR;
      end else begin
        kind = roll < 20 ? KIND_INSERT : roll < 60 ? KIND_DELETE : roll < 98 ? KIND_FIND
                         : KIND_CLEAR;
      end
      size = shadow_list.size();
      pos  = PosW'($urandom);
      // Mostly legal positions, with some out of range.
      if ($urandom_range(0, 99) < 85) begin
        if (kind == KIND_INSERT) pos = PosW'($urandom_range(0, size > 63 ? 63 : size));
        else if (kind == KIND_DELETE && size != 0) pos = PosW'($urandom_range(0, size - 1));
      end
      send_req(kind, pos, pick_value());
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.kind     <= KIND_INSERT;
    req_if.position <= '0;
    req_if.value    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edit_and_find();
    test_full_list();
    test_backpressure();
    test_random_traffic();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
